@@ rtl/nrs_pkg.sv @@
package nrs_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int WORD_W      = 32;

    // record layout, lowest bit first: node_id, rssi, flag
    localparam int ID_LSB   = 0;
    localparam int RSSI_LSB = 16;
    localparam int FLAG_LSB = 24;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_OUT_RD,
        ST_OUT_LD
    } state_t;

endpackage

@@ rtl/nrs_ram.sv @@
module nrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // read data holds while no read is issued
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/neighbor_rssi_sorter_core.sv @@
// sequence: after the accept, one compare per stored entry the item moves past, each weaker entry
// shifted up one place, then the final compare or write; a full store drops the item at once
// a last item then emits count results, each a store read then an output register load
// flow: ready is high only between items, so no new item is taken before the current one is through
// reset: aresetn (sync, active low) empties the store and drops any pending result;
// store contents are not cleared, only entries below the fill count are ever read
module neighbor_rssi_sorter_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    // input record stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [31:0]                s_tdata,   // node_id[15:0], rssi[23:16], mark_flag[31:24]
    input  logic                       s_tlast,   // last_entry
    // sorted result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,   // out_node_id[15:0], out_rssi[23:16], out_flag[31:24]
    output logic                       m_tlast    // out_last
);

    import nrs_pkg::*;

    // control registers
    state_t              state_reg,   state_next;
    logic [CNT_W-1:0]    count_reg,   count_next;   // number of stored records
    logic [ADDR_W-1:0]   pos_reg,     pos_next;     // hole position during insertion
    logic [ADDR_W-1:0]   k_reg,       k_next;       // output read index
    logic                last_reg,    last_next;    // current item carries the last mark
    logic                m_valid_reg, m_valid_next;

    // payload registers
    logic [WORD_W-1:0]   word_reg,    word_next;
    logic [WORD_W-1:0]   m_data_reg,  m_data_next;
    logic                m_last_reg,  m_last_next;

    // store port signals
    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    logic [WORD_W-1:0]   ram_wr_data;
    logic                ram_rd_en;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [WORD_W-1:0]   ram_rd_data;

    logic                s_fire;
    logic                out_free;
    logic                rd_weaker;   // stored entry strictly weaker than the new record
    logic                store_full;
    logic                out_is_last;

    nrs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign store_full = (count_reg == CNT_W'(MAX_ENTRIES));

    // signed key compare; ties stop the walk so equal keys keep arrival order
    assign rd_weaker = $signed(ram_rd_data[RSSI_LSB +: 8]) < $signed(word_reg[RSSI_LSB +: 8]);

    assign out_is_last = ((CNT_W'(k_reg) + CNT_W'(1)) == count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            pos_reg     <= '0;
            k_reg       <= '0;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pos_reg     <= pos_next;
            k_reg       <= k_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg   <= word_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        k_next       = k_reg;
        last_next    = last_reg;
        word_next    = word_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;

        ram_wr_en    = 1'b0;
        ram_wr_addr  = pos_reg;
        ram_wr_data  = word_reg;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = pos_reg - ADDR_W'(1);

        // result register drains independently of the sequencer
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    word_next = s_tdata;
                    last_next = s_tlast;
                    k_next    = '0;
                    if (store_full) begin
                        // record dropped, a last mark still flushes the store
                        state_next = s_tlast ? ST_OUT_RD : ST_IDLE;
                    end else begin
                        pos_next = count_reg[ADDR_W-1:0];
                        if (count_reg != '0) begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = count_reg[ADDR_W-1:0] - ADDR_W'(1);
                            state_next  = ST_INS_CMP;
                        end else begin
                            state_next = ST_INS_PUT;
                        end
                    end
                end
            end

            ST_INS_CMP: begin
                // read data is entry pos-1
                ram_wr_en = 1'b1;
                if (rd_weaker) begin
                    // shift the weaker entry up one place
                    ram_wr_data = ram_rd_data;
                    pos_next    = pos_reg - ADDR_W'(1);
                    if (pos_reg != ADDR_W'(1)) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = pos_reg - ADDR_W'(2);
                    end else begin
                        state_next = ST_INS_PUT;
                    end
                end else begin
                    ram_wr_data = word_reg;
                    count_next  = count_reg + CNT_W'(1);
                    state_next  = last_reg ? ST_OUT_RD : ST_IDLE;
                end
            end

            ST_INS_PUT: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = word_reg;
                count_next  = count_reg + CNT_W'(1);
                state_next  = last_reg ? ST_OUT_RD : ST_IDLE;
            end

            ST_OUT_RD: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = k_reg;
                state_next  = ST_OUT_LD;
            end

            ST_OUT_LD: begin
                // store read data holds until the result register frees up
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = ram_rd_data;
                    m_last_next  = out_is_last;
                    k_next       = k_reg + ADDR_W'(1);
                    if (out_is_last) begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_OUT_RD;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // fill count never passes the store depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("fill count beyond store depth");

    // the insertion walk only compares while a lower entry exists
    a_walk_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INS_CMP) |-> (pos_reg != '0))
        else $error("insertion compare with no entry below");

    // output sweep reads only filled entries
    a_out_index: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_OUT_RD) || (state_reg == ST_OUT_LD)) |->
            (CNT_W'(k_reg) < count_reg))
        else $error("output read beyond fill count");

    // a new result is loaded only into a free result register
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready && (state_reg == ST_OUT_LD)) |=> (state_reg == ST_OUT_LD))
        else $error("result register overwritten while stalled");

endmodule
